/* hdl/slfp_pkg.sv */
// ----------------------------------------------------------------------------
// slfp_pkg: shared types and constants of the sync/length/sum frame parser
// Holds the sync and id codes, the result kinds, the payload store depth and
// the result record passed from the frame decoder to the top level.
// ----------------------------------------------------------------------------
package slfp_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'h66;
   localparam logic [7:0] SYNC_SECOND = 8'hCC;
   localparam logic [7:0] ID_STATE    = 8'h02;
   localparam logic [7:0] ID_PID      = 8'h05;

   localparam int STORE_DEPTH = 9;
   localparam int STORE_IDX_W = 4;

   localparam logic signed [16:0] WORD_OFFSET = 17'sd30000;

   localparam logic [2:0] KIND_STATE    = 3'd0;
   localparam logic [2:0] KIND_PID      = 3'd1;
   localparam logic [2:0] KIND_OTHER    = 3'd2;
   localparam logic [2:0] KIND_CHECKSUM = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   typedef logic [STORE_DEPTH-1:0][7:0] slfp_store_type;

   typedef struct packed {
      logic [2:0]         frame_kind;
      logic [7:0]         frame_ident;
      logic signed [16:0] value_a;
      logic signed [16:0] value_b;
      logic signed [16:0] value_c;
      logic signed [16:0] value_d;
      logic [7:0]         brake_level;
   } slfp_result_type;

   // big-endian byte pair minus the word offset
   function automatic logic signed [16:0] word_at(input logic [7:0] hi, input logic [7:0] lo);
      word_at = $signed({1'b0, hi, lo}) - WORD_OFFSET;
   endfunction

endpackage

/* hdl/sync_length_sum_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// sync_length_sum_frame_parser_core: serial frame parser, one byte per word
// Hunts for the sync pair, reads id and length, stores the payload, checks
// the 8-bit sum and reports one result word per completed or overflowing frame.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per word in req_tdata[7:0].
//   rsp_* carries one result word per frame: rsp_tuser holds frame_kind
//   (0 state, 1 pid, 2 other id, 3 checksum error, 4 overflow); rsp_tdata
//   holds ident, value_a..value_d and brake_level.
//   Throughput: one byte per cycle while req_tready is high. Each byte is parsed in the cycle it is
//   accepted; the parser state and the payload store update at that edge.
//   The result of a frame appears in rsp_tvalid in the cycle after its
//   checksum byte (or the overflowing byte) is accepted.
//   The single output register decouples the two sides: req_tready stays
//   high while the output register is empty or being drained, so a byte is
//   taken in the same cycle a pending result leaves. When the receiver
//   stalls with a result pending, req_tready drops until that result is
//   taken; nothing is lost.
//   Reset (synchronous, active high) returns the parser to sync hunting,
//   clears the sum, id, length and store, and empties the output register.
//   Frames needing length + 4 >= MAX_FRAME always end with an overflow word.
// ----------------------------------------------------------------------------
module sync_length_sum_frame_parser_core
   import slfp_pkg::*;
#(
   parameter int MAX_FRAME = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [7:0] frame_ident, [24:8] value_a,
                                    // [41:25] value_b, [58:42] value_c,
                                    // [75:59] value_d, [83:76] brake_level
   output logic [2:0]  rsp_tuser    // [2:0] frame_kind
);

   // index counts up to MAX_FRAME; end-of-frame compare needs length + 4
   localparam int IDX_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = (IDX_W > 9) ? IDX_W : 9;

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]       ident_ff, ident_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       sum_ff, sum_in;
   slfp_store_type   store_ff, store_in;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   slfp_result_type  rsp_ff, rsp_in;

   logic             accept;
   logic [7:0]       in_byte;
   logic [IDX_W-1:0] pos;
   logic             end_of_frame;
   logic             res_valid;
   slfp_result_type  res;
   slfp_result_type  frame_res;

   assign in_byte    = req_tdata;
   // accept while the output register is empty or draining this cycle
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos          = byte_index_ff - IDX_W'(4);
   assign end_of_frame = (CMP_W'(byte_index_ff) == (CMP_W'(length_ff) + CMP_W'(4)));

   slfp_decode u_decode (
      .ident    (ident_ff),
      .sum_ok   (in_byte == sum_ff),
      .store    (store_ff),
      .result   (frame_res)
   );

   always_comb begin
      byte_index_in = byte_index_ff;
      ident_in      = ident_ff;
      length_in     = length_ff;
      sum_in        = sum_ff;
      store_in      = store_ff;
      res_valid     = 1'b0;
      res           = '0;
      if (accept) begin
         if (byte_index_ff == '0) begin
            // hunting: a first sync byte opens a frame and clears the store
            if (in_byte == SYNC_FIRST) begin
               store_in      = '0;
               sum_in        = '0;
               byte_index_in = IDX_W'(1);
            end
         end else if (byte_index_ff == IDX_W'(1)) begin
            // a bad second sync byte drops back to hunting, not rechecked
            byte_index_in = (in_byte == SYNC_SECOND) ? IDX_W'(2) : '0;
         end else if (CMP_W'(byte_index_ff) >= CMP_W'(MAX_FRAME)) begin
            // frame bound hit: drop the byte and report overflow
            byte_index_in    = '0;
            res_valid        = 1'b1;
            res.frame_kind   = KIND_OVERFLOW;
         end else if (byte_index_ff == IDX_W'(2)) begin
            ident_in      = in_byte;
            sum_in        = in_byte;
            byte_index_in = IDX_W'(3);
         end else if (byte_index_ff == IDX_W'(3)) begin
            length_in     = in_byte;
            sum_in        = sum_ff + in_byte;
            byte_index_in = IDX_W'(4);
         end else if (end_of_frame) begin
            // checksum byte: classify and emit the frame
            byte_index_in = '0;
            res_valid     = 1'b1;
            res           = frame_res;
         end else begin
            // payload: store the first bytes, sum them all
            if (pos < IDX_W'(STORE_DEPTH)) begin
               store_in[pos[STORE_IDX_W-1:0]] = in_byte;
            end
            sum_in        = sum_ff + in_byte;
            byte_index_in = byte_index_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_in        = rsp_ff;
      if (accept && res_valid) begin
         rsp_tvalid_in = 1'b1;
         rsp_in        = res;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         ident_ff      <= '0;
         length_ff     <= '0;
         sum_ff        <= '0;
         store_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         ident_ff      <= ident_in;
         length_ff     <= length_in;
         sum_ff        <= sum_in;
         store_ff      <= store_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // result payload: hold while stalled, load on a new result
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ff.frame_kind;
   assign rsp_tdata  = {4'b0000, rsp_ff.brake_level, rsp_ff.value_d, rsp_ff.value_c,
                        rsp_ff.value_b, rsp_ff.value_a, rsp_ff.frame_ident};

endmodule

/* hdl/slfp_decode.sv */
// ----------------------------------------------------------------------------
// slfp_decode: result formation for a completed frame
// Classifies the frame by checksum and id and extracts the payload words.
// ----------------------------------------------------------------------------
module slfp_decode
   import slfp_pkg::*;
(
   input  logic [7:0]      ident,
   input  logic            sum_ok,
   input  slfp_store_type  store,
   output slfp_result_type result
);

   always_comb begin
      result             = '0;
      result.frame_ident = ident;
      if (!sum_ok) begin
         result.frame_kind = KIND_CHECKSUM;
      end else begin
         unique case (ident)
            ID_STATE: begin
               result.frame_kind  = KIND_STATE;
               result.value_a     = word_at(store[0], store[1]);
               result.value_b     = word_at(store[2], store[3]);
               result.value_c     = word_at(store[4], store[5]);
               result.value_d     = word_at(store[6], store[7]);
               result.brake_level = store[8];
            end
            ID_PID: begin
               result.frame_kind = KIND_PID;
               result.value_a    = word_at(store[0], store[1]);
               result.value_b    = word_at(store[2], store[3]);
               result.value_c    = word_at(store[4], store[5]);
            end
            default: begin
               result.frame_kind = KIND_OTHER;
            end
         endcase
      end
   end

endmodule
